>>> hw/rtl/ibcs_pkg.sv
package ibcs_pkg;

   localparam int TIMER_WIDTH_DEF = 16;
   localparam int HALF_W          = 16;
   localparam int LIMIT_W         = 16;
   localparam int PULSE_W         = 4;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;

   localparam logic [HALF_W-1:0]  HALF_PERIOD_RESET = 16'd10;
   localparam logic [LIMIT_W-1:0] SCL_WAIT_RESET    = 16'd1000;
   localparam logic [PULSE_W-1:0] MAX_PULSES_RESET  = 4'd9;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCL_WAIT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PULSES  = 2'd2;

   // Completion status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_STUCK  = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   typedef enum logic [8:0] {
      PH_IDLE          = 9'b000000001,
      PH_INIT_HALF     = 9'b000000010,
      PH_PULSE_LOW     = 9'b000000100,
      PH_PULSE_WAIT    = 9'b000001000,
      PH_PULSE_HIGH    = 9'b000010000,
      PH_START_SDA_LOW = 9'b000100000,
      PH_STOP_SCL_LOW  = 9'b001000000,
      PH_STOP_SCL_HIGH = 9'b010000000,
      PH_STOP_SDA_HIGH = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic kind;
      logic sda_level;
      logic scl_level;
   } req_type;

   typedef struct packed {
      logic               scl_release;
      logic               sda_release;
      logic               busy_res;
      logic               done_res;
      logic [1:0]         status;
      logic [PULSE_W-1:0] pulses_sent;
      logic               sda_freed;
      logic               scl_timeout_seen;
      logic               clear_performed;
   } rsp_type;

   typedef struct packed {
      logic [HALF_W-1:0]  half_period_ticks;
      logic [LIMIT_W-1:0] scl_wait_limit;
      logic [PULSE_W-1:0] max_pulses;
   } cfg_type;

endpackage

>>> hw/rtl/ibcs_csr.sv
module ibcs_csr
   import ibcs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: cfg_in.half_period_ticks = csr_data[HALF_W-1:0];
            CSR_SCL_WAIT:    cfg_in.scl_wait_limit    = csr_data[LIMIT_W-1:0];
            CSR_MAX_PULSES:  cfg_in.max_pulses        = csr_data[PULSE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= HALF_PERIOD_RESET;
         cfg_ff.scl_wait_limit    <= SCL_WAIT_RESET;
         cfg_ff.max_pulses        <= MAX_PULSES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/ibcs_in_stage.sv
module ibcs_in_stage
   import ibcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   input  logic    advance,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    take;

   assign req_ready  = !valid_ff || advance;
   assign take       = req_valid && req_ready;
   assign valid_in   = take || (valid_ff && !advance);
   assign item_valid = valid_ff;
   assign item       = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_payload;
      end
   end

endmodule

>>> hw/rtl/ibcs_engine.sv
module ibcs_engine
   import ibcs_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int CW = ((TIMER_WIDTH > HALF_W) ? TIMER_WIDTH : HALF_W) + 1;

   phase_type              phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] delay_ff, delay_in;
   logic [TIMER_WIDTH-1:0] wait_ff, wait_in;
   logic [PULSE_W-1:0]     pulse_ff, pulse_in;
   logic                   freed_ff, freed_in;
   logic                   tmo_ff, tmo_in;
   logic                   clear_ff, clear_in;

   logic [CW-1:0]          dly_plus;
   logic [CW-1:0]          half_eff;
   logic                   dly_over;
   logic [TIMER_WIDTH-1:0] dly_next;
   logic                   wait_out;
   logic [PULSE_W-1:0]     pulse_inc;
   logic                   start_left;
   logic                   done;
   logic [1:0]             status;

   // A zero half period counts as one tick; a saturated counter also ends a delay.
   assign dly_plus  = CW'(delay_ff) + CW'(1);
   assign half_eff  = (cfg.half_period_ticks == '0) ? CW'(1) : CW'(cfg.half_period_ticks);
   assign dly_over  = (dly_plus >= half_eff) || (delay_ff == '1);
   assign dly_next  = dly_over ? '0 : dly_plus[TIMER_WIDTH-1:0];
   assign wait_out  = (CW'(wait_ff) >= CW'(cfg.scl_wait_limit)) || (wait_ff == '1);
   assign pulse_inc = pulse_ff + PULSE_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      delay_in   = delay_ff;
      wait_in    = wait_ff;
      pulse_in   = pulse_ff;
      freed_in   = freed_ff;
      tmo_in     = tmo_ff;
      clear_in   = clear_ff;
      start_left = item.kind;
      done       = 1'b0;
      status     = ST_OK;

      unique case (phase_ff)
         PH_IDLE: begin
            if (item.kind) begin
               pulse_in   = '0;
               freed_in   = 1'b0;
               tmo_in     = 1'b0;
               clear_in   = 1'b0;
               delay_in   = '0;
               wait_in    = '0;
               start_left = 1'b0;
               if (item.sda_level && item.scl_level) begin
                  done = 1'b1;
               end else begin
                  clear_in = 1'b1;
                  phase_in = PH_INIT_HALF;
               end
            end else begin
               clear_in = clear_ff;
            end
         end
         PH_INIT_HALF: begin
            delay_in = dly_next;
            if (dly_over) begin
               if (item.sda_level || (cfg.max_pulses == '0)) begin
                  phase_in = PH_START_SDA_LOW;
               end else begin
                  phase_in = PH_PULSE_LOW;
               end
            end
         end
         PH_PULSE_LOW: begin
            delay_in = dly_next;
            if (dly_over) begin
               wait_in  = '0;
               phase_in = PH_PULSE_WAIT;
            end
         end
         PH_PULSE_WAIT: begin
            if (item.scl_level) begin
               phase_in = PH_PULSE_HIGH;
            end else if (wait_out) begin
               tmo_in   = 1'b1;
               phase_in = PH_PULSE_HIGH;
            end else begin
               wait_in = wait_ff + TIMER_WIDTH'(1);
            end
         end
         PH_PULSE_HIGH: begin
            delay_in = dly_next;
            if (dly_over) begin
               pulse_in = pulse_inc;
               if (item.sda_level) begin
                  freed_in = 1'b1;
                  phase_in = PH_START_SDA_LOW;
               end else if (pulse_inc >= cfg.max_pulses) begin
                  phase_in = PH_START_SDA_LOW;
               end else begin
                  phase_in = PH_PULSE_LOW;
               end
            end
         end
         PH_START_SDA_LOW: begin
            delay_in = dly_next;
            if (dly_over) begin
               phase_in = PH_STOP_SCL_LOW;
            end
         end
         PH_STOP_SCL_LOW: begin
            delay_in = dly_next;
            if (dly_over) begin
               phase_in = PH_STOP_SCL_HIGH;
            end
         end
         PH_STOP_SCL_HIGH: begin
            delay_in = dly_next;
            if (dly_over) begin
               phase_in = PH_STOP_SDA_HIGH;
            end
         end
         PH_STOP_SDA_HIGH: begin
            delay_in = dly_next;
            if (dly_over) begin
               done       = 1'b1;
               status     = (item.sda_level && item.scl_level) ? ST_OK : ST_STUCK;
               phase_in   = PH_IDLE;
               start_left = 1'b0;
            end
         end
         default: begin
            phase_in   = PH_IDLE;
            delay_in   = '0;
            wait_in    = '0;
            start_left = 1'b0;
         end
      endcase

      // A start that arrives while a sequence runs is refused, and the sequence goes on.
      if (start_left && !done) begin
         done   = 1'b1;
         status = ST_REJECT;
      end

      result.scl_release      = !((phase_in == PH_PULSE_LOW) || (phase_in == PH_STOP_SCL_LOW));
      result.sda_release      = !((phase_in == PH_START_SDA_LOW) ||
                                  (phase_in == PH_STOP_SCL_LOW) ||
                                  (phase_in == PH_STOP_SCL_HIGH));
      result.busy_res         = (phase_in != PH_IDLE);
      result.done_res         = done;
      result.status           = status;
      result.pulses_sent      = pulse_in;
      result.sda_freed        = freed_in;
      result.scl_timeout_seen = tmo_in;
      result.clear_performed  = clear_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         delay_ff <= '0;
         wait_ff  <= '0;
         pulse_ff <= '0;
         freed_ff <= 1'b0;
         tmo_ff   <= 1'b0;
         clear_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         wait_ff  <= wait_in;
         pulse_ff <= pulse_in;
         freed_ff <= freed_in;
         tmo_ff   <= tmo_in;
         clear_ff <= clear_in;
      end
   end

endmodule

>>> hw/rtl/ibcs_out_stage.sv
module ibcs_out_stage
   import ibcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type result,
   output logic    advance,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // The result register may take a new item whenever it is empty or being drained.
   assign advance     = !valid_ff || rsp_ready;
   assign valid_in    = load || (valid_ff && !rsp_ready);
   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

>>> hw/rtl/i2c_bus_clear_sequencer.sv
// A request reaches its response through the input register and then the result register.
// One tick per cycle unless stalled; the recovery state machine steps once per accepted tick.
// Only a stalled response channel slows the input side, through the result register.
// Reset is synchronous: phase goes idle, counters and flags clear, and the configuration
// registers return to half period 10, SCL wait limit 1000 and nine pulses.
module i2c_bus_clear_sequencer
   import ibcs_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;
   logic    advance;
   logic    item_valid;
   req_type item;
   rsp_type result;
   logic    step;

   assign step = item_valid && advance;

   ibcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ibcs_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   ibcs_engine #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   ibcs_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (step),
      .result      (result),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_status_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.done_res |-> rsp_payload.status == ST_OK)
      else $error("status set without done");

   a_idle_lines_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.busy_res |->
         rsp_payload.scl_release && rsp_payload.sda_release)
      else $error("bus driven low while idle");

   a_reject_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_REJECT) |-> rsp_payload.busy_res)
      else $error("start rejected while idle");

   a_step_fills_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("processed tick lost before the result register");

endmodule

>>> dv/tb_i2c_bus_clear_sequencer.sv
`timescale 1ns / 1ps

module tb_i2c_bus_clear_sequencer;
   import ibcs_pkg::*;

   localparam int LIMIT_NS        = 200_000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_CYCLES     = 300;
   localparam int RAND_PHASES     = 12;
   localparam int TICKS_PER_PHASE = 90;
   localparam int BUSY_IDLE_PCT   = 35;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   // Index 3 is not a register; writes to it must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {ROW_TICK, ROW_CSR} row_op_type;

   typedef struct packed {
      row_op_type             op;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  data;
      req_type                req;
      logic [19:0]            reps;
      logic                   typed;
      rsp_type                want;
   } dir_row_type;

   localparam req_type IDLE_REQ = '{KIND_TICK, 1'b0, 1'b0};
   localparam rsp_type UNTYPED  = '0;
   localparam rsp_type IDLE_RSP =
      '{1'b1, 1'b1, 1'b0, 1'b0, ST_OK, 4'd0, 1'b0, 1'b0, 1'b0};
   localparam rsp_type START_OK_RSP =
      '{1'b1, 1'b1, 1'b0, 1'b1, ST_OK, 4'd0, 1'b0, 1'b0, 1'b0};
   localparam rsp_type CLEAR_BEGIN_RSP =
      '{1'b1, 1'b1, 1'b1, 1'b0, ST_OK, 4'd0, 1'b0, 1'b0, 1'b1};
   localparam rsp_type REJECT_RSP =
      '{1'b1, 1'b1, 1'b1, 1'b1, ST_REJECT, 4'd0, 1'b0, 1'b0, 1'b1};

   localparam int DIR_COUNT = 23;
   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_TICK, 1'b0, 1'b0}, 20'd1, 1'b1, IDLE_RSP},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_TICK, 1'b1, 1'b1}, 20'd1, 1'b1, IDLE_RSP},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_START, 1'b1, 1'b1}, 20'd1, 1'b1,
        START_OK_RSP},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_START, 1'b0, 1'b1}, 20'd1, 1'b1,
        CLEAR_BEGIN_RSP},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_START, 1'b0, 1'b1}, 20'd1, 1'b1,
        REJECT_RSP},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_TICK, 1'b0, 1'b1}, 20'd250, 1'b0, UNTYPED},
      // Zero half period counts as one tick; zero wait limit checks SCL once.
      '{ROW_CSR, CSR_HALF_PERIOD, 16'd0, IDLE_REQ, 20'd0, 1'b0, UNTYPED},
      '{ROW_CSR, CSR_SCL_WAIT, 16'd0, IDLE_REQ, 20'd0, 1'b0, UNTYPED},
      '{ROW_CSR, CSR_MAX_PULSES, 16'hfff0, IDLE_REQ, 20'd0, 1'b0, UNTYPED},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_START, 1'b0, 1'b0}, 20'd1, 1'b0, UNTYPED},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_TICK, 1'b0, 1'b0}, 20'd20, 1'b0, UNTYPED},
      '{ROW_CSR, CSR_MAX_PULSES, 16'h000f, IDLE_REQ, 20'd0, 1'b0, UNTYPED},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_START, 1'b0, 1'b0}, 20'd1, 1'b0, UNTYPED},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_TICK, 1'b0, 1'b0}, 20'd80, 1'b0, UNTYPED},
      // Long SCL wait that runs out at its limit.
      '{ROW_CSR, CSR_SCL_WAIT, 16'd100, IDLE_REQ, 20'd0, 1'b0, UNTYPED},
      '{ROW_CSR, CSR_HALF_PERIOD, 16'd1, IDLE_REQ, 20'd0, 1'b0, UNTYPED},
      '{ROW_CSR, CSR_MAX_PULSES, 16'd1, IDLE_REQ, 20'd0, 1'b0, UNTYPED},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_START, 1'b0, 1'b0}, 20'd1, 1'b0, UNTYPED},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_TICK, 1'b0, 1'b0}, 20'd120, 1'b0,
        UNTYPED},
      // A longer half period, with SDA high so no pulses are sent.
      '{ROW_CSR, CSR_HALF_PERIOD, 16'd30, IDLE_REQ, 20'd0, 1'b0, UNTYPED},
      '{ROW_CSR, CSR_UNUSED, 16'hffff, IDLE_REQ, 20'd0, 1'b0, UNTYPED},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_START, 1'b1, 1'b0}, 20'd1, 1'b0, UNTYPED},
      '{ROW_TICK, CSR_HALF_PERIOD, 16'd0, '{KIND_TICK, 1'b1, 1'b1}, 20'd160, 1'b0,
        UNTYPED}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   i2c_bus_clear_sequencer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   // Recovery predictor state and its copy of the registers.
   cfg_type     recov_cfg = '{HALF_PERIOD_RESET, SCL_WAIT_RESET, MAX_PULSES_RESET};
   phase_type   ph = PH_IDLE;
   int unsigned dly_cnt = 0;
   int unsigned wait_cnt = 0;
   logic [3:0]  pulses = '0;
   bit          freed = 0;
   bit          tmo = 0;
   bit          cleared = 0;

   rsp_type     pending[$];
   rsp_type     bus_drive = IDLE_RSP;

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   bit          hold_rsp = 0;
   bit          sda_stuck = 0;
   int unsigned scl_stretch = 0;

   int unsigned errors = 0;
   int unsigned n_ticks = 0;
   int unsigned n_writes = 0;
   int unsigned n_results = 0;
   int unsigned n_ok = 0;
   int unsigned n_stuck = 0;
   int unsigned n_reject = 0;
   int unsigned n_tmo = 0;
   int unsigned n_freed = 0;

   function automatic int unsigned eff_half();
      return (recov_cfg.half_period_ticks == 0) ? 1 : recov_cfg.half_period_ticks;
   endfunction

   // Advances the half-period counter; true on its last tick.
   function automatic bit half_elapsed();
      if (dly_cnt + 1 >= eff_half() || dly_cnt >= 32'hffff) begin
         dly_cnt = 0;
         return 1'b1;
      end
      dly_cnt = dly_cnt + 1;
      return 1'b0;
   endfunction

   function automatic bit finishing_next();
      return ph == PH_STOP_SDA_HIGH && dly_cnt + 1 >= eff_half();
   endfunction

   function automatic rsp_type step_bus_clear(input req_type r);
      bit         start;
      bit         fin;
      logic [1:0] st;
      rsp_type    o;
      start = r.kind == KIND_START;
      fin = 1'b0;
      st = ST_OK;
      case (ph)
         PH_IDLE: begin
            if (start) begin
               pulses = '0;
               freed = 0;
               tmo = 0;
               cleared = 0;
               dly_cnt = 0;
               wait_cnt = 0;
               if (r.sda_level && r.scl_level) begin
                  fin = 1'b1;
               end else begin
                  cleared = 1;
                  ph = PH_INIT_HALF;
               end
               start = 1'b0;
            end
         end
         PH_INIT_HALF: begin
            if (half_elapsed())
               ph = (r.sda_level || recov_cfg.max_pulses == 0) ? PH_START_SDA_LOW
                                                               : PH_PULSE_LOW;
         end
         PH_PULSE_LOW: begin
            if (half_elapsed()) begin
               wait_cnt = 0;
               ph = PH_PULSE_WAIT;
            end
         end
         PH_PULSE_WAIT: begin
            if (r.scl_level) begin
               ph = PH_PULSE_HIGH;
            end else if (wait_cnt >= recov_cfg.scl_wait_limit || wait_cnt >= 32'hffff) begin
               tmo = 1;
               ph = PH_PULSE_HIGH;
            end else begin
               wait_cnt = wait_cnt + 1;
            end
         end
         PH_PULSE_HIGH: begin
            if (half_elapsed()) begin
               pulses = pulses + 4'd1;
               if (r.sda_level) begin
                  freed = 1;
                  ph = PH_START_SDA_LOW;
               end else if (pulses >= recov_cfg.max_pulses) begin
                  ph = PH_START_SDA_LOW;
               end else begin
                  ph = PH_PULSE_LOW;
               end
            end
         end
         PH_START_SDA_LOW: if (half_elapsed()) ph = PH_STOP_SCL_LOW;
         PH_STOP_SCL_LOW: if (half_elapsed()) ph = PH_STOP_SCL_HIGH;
         PH_STOP_SCL_HIGH: if (half_elapsed()) ph = PH_STOP_SDA_HIGH;
         PH_STOP_SDA_HIGH: begin
            if (half_elapsed()) begin
               fin = 1'b1;
               st = (r.sda_level && r.scl_level) ? ST_OK : ST_STUCK;
               ph = PH_IDLE;
               start = 1'b0;
            end
         end
         default: begin
            ph = PH_IDLE;
            dly_cnt = 0;
            wait_cnt = 0;
            start = 1'b0;
         end
      endcase
      if (start && !fin) begin
         fin = 1'b1;
         st = ST_REJECT;
      end
      o.scl_release = !(ph == PH_PULSE_LOW || ph == PH_STOP_SCL_LOW);
      o.sda_release = !(ph == PH_START_SDA_LOW || ph == PH_STOP_SCL_LOW ||
                        ph == PH_STOP_SCL_HIGH);
      o.busy_res = ph != PH_IDLE;
      o.done_res = fin;
      o.status = st;
      o.pulses_sent = pulses;
      o.sda_freed = freed;
      o.scl_timeout_seen = tmo;
      o.clear_performed = cleared;
      return o;
   endfunction

   // Line levels follow what the block drives, with a stuck SDA, SCL stretching by a
   // target and some noise. Starts are aimed at the finishing tick now and then.
   function automatic req_type pick_tick();
      req_type r;
      if (ph == PH_IDLE)
         r.kind = ($urandom_range(0, 99) < 12) ? KIND_START : KIND_TICK;
      else if (finishing_next())
         r.kind = $urandom_range(0, 1) ? KIND_START : KIND_TICK;
      else
         r.kind = ($urandom_range(0, 99) < 3) ? KIND_START : KIND_TICK;
      if ($urandom_range(0, 99) < 8) begin
         r.sda_level = 1'($urandom_range(0, 1));
         r.scl_level = 1'($urandom_range(0, 1));
         return r;
      end
      if (ph == PH_IDLE && r.kind == KIND_START) begin
         sda_stuck = $urandom_range(0, 99) < 70;
         scl_stretch = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 12) : 0;
      end else if (sda_stuck && $urandom_range(0, 29) == 0) begin
         sda_stuck = 0;
      end
      if (scl_stretch == 0 && ph == PH_PULSE_WAIT && $urandom_range(0, 99) < 20)
         scl_stretch = $urandom_range(1, 10);
      r.sda_level = bus_drive.sda_release && !sda_stuck;
      r.scl_level = bus_drive.scl_release && scl_stretch == 0;
      if (scl_stretch != 0)
         scl_stretch = scl_stretch - 1;
      return r;
   endfunction

   function automatic void same_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending.size() == 0) begin
         $error("result transfer with nothing pending: %h", got);
         errors++;
         return;
      end
      want = pending.pop_front();
      same_field("scl_release", want.scl_release, got.scl_release);
      same_field("sda_release", want.sda_release, got.sda_release);
      same_field("busy_res", want.busy_res, got.busy_res);
      same_field("done_res", want.done_res, got.done_res);
      same_field("status", want.status, got.status);
      same_field("pulses_sent", want.pulses_sent, got.pulses_sent);
      same_field("sda_freed", want.sda_freed, got.sda_freed);
      same_field("scl_timeout_seen", want.scl_timeout_seen, got.scl_timeout_seen);
      same_field("clear_performed", want.clear_performed, got.clear_performed);
      n_results++;
      if (want.done_res) begin
         if (want.status == ST_OK) n_ok++;
         if (want.status == ST_STUCK) n_stuck++;
         if (want.status == ST_REJECT) n_reject++;
         if (want.status != ST_REJECT && want.scl_timeout_seen) n_tmo++;
         if (want.status != ST_REJECT && want.sda_freed) n_freed++;
      end
   endtask

   task automatic send_tick(input req_type r, input bit typed, input rsp_type want);
      rsp_type pred;
      csr_valid <= 1'b0;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      pred = step_bus_clear(r);
      pending.push_back(typed ? want : pred);
      bus_drive = pred;
      n_ticks++;
   endtask

   // Stops offering and waits until every expected result has been seen.
   task automatic drain();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HALF_PERIOD: recov_cfg.half_period_ticks = data;
         CSR_SCL_WAIT: recov_cfg.scl_wait_limit = data;
         CSR_MAX_PULSES: recov_cfg.max_pulses = data[PULSE_W-1:0];
         default: ;
      endcase
      n_writes++;
   endtask

   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 0;
            repeat (HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            check_result(rsp_payload);
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_COUNT; i++) begin
         if (DIR_ROWS[i].op == ROW_CSR) begin
            if (i == 0 || DIR_ROWS[i-1].op != ROW_CSR)
               drain();
            write_csr(DIR_ROWS[i].idx, DIR_ROWS[i].data);
         end else begin
            repeat (DIR_ROWS[i].reps)
               send_tick(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].want);
         end
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         drain();
         write_csr(CSR_HALF_PERIOD, ($urandom_range(0, 9) == 0) ?
                   16'($urandom_range(0, 12)) : 16'($urandom_range(1, 3)));
         write_csr(CSR_SCL_WAIT, ($urandom_range(0, 4) == 0) ?
                   16'($urandom_range(7, 40)) : 16'($urandom_range(0, 6)));
         write_csr(CSR_MAX_PULSES, 16'($urandom_range(0, 16'hffff)));
         if (p == 4)
            write_csr(CSR_UNUSED, 16'($urandom_range(0, 16'hffff)));
         // One phase runs with no idling on either side.
         req_idle_pct = (p == 5) ? 0 : BUSY_IDLE_PCT;
         rsp_idle_pct = (p == 5) ? 0 : BUSY_IDLE_PCT;
         for (int k = 0; k < TICKS_PER_PHASE; k++) begin
            if (p == 3 && k == 70)
               drain();
            // The receiver holds off while ticks keep coming, so the block backs up.
            if (p == 7 && k == 20)
               hold_rsp = 1;
            send_tick(pick_tick(), 1'b0, UNTYPED);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (pending.size() != 0) begin
         $error("%0d expected results never arrived", pending.size());
         errors++;
      end
      $display("Sent %0d ticks and %0d register writes; %0d results checked.",
               n_ticks, n_writes, n_results);
      $display("Recoveries ok %0d, stuck %0d, starts rejected %0d, with SCL timeout %0d, %s %0d",
               n_ok, n_stuck, n_reject, n_tmo, "SDA freed", n_freed);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
